/* src/rvid_pkg.sv */
// ----------------------------------------------------------------------------
// rvid_pkg
// Shared types and constants for the RV64I instruction decoder.
// ----------------------------------------------------------------------------
package rvid_pkg;

   localparam int unsigned InstrWidth = 32;
   localparam int unsigned ImmWidth   = 64;

   // major opcodes, instr[6:0]
   localparam logic [6:0] OPC_LUI    = 7'b0110111;
   localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
   localparam logic [6:0] OPC_JAL    = 7'b1101111;
   localparam logic [6:0] OPC_JALR   = 7'b1100111;
   localparam logic [6:0] OPC_BRANCH = 7'b1100011;
   localparam logic [6:0] OPC_LOAD   = 7'b0000011;
   localparam logic [6:0] OPC_STORE  = 7'b0100011;
   localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
   localparam logic [6:0] OPC_OP     = 7'b0110011;
   localparam logic [6:0] OPC_FENCE  = 7'b0001111;
   localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
   localparam logic [6:0] OPC_OPIMMW = 7'b0011011;
   localparam logic [6:0] OPC_OPW    = 7'b0111011;

   localparam logic [6:0] F7_BASE = 7'b0000000;
   localparam logic [6:0] F7_ALT  = 7'b0100000;
   localparam logic [5:0] F6_BASE = 6'b000000;
   localparam logic [5:0] F6_ALT  = 6'b010000;

   localparam logic [11:0] F12_ECALL  = 12'd0;
   localparam logic [11:0] F12_EBREAK = 12'd1;

   typedef enum logic [5:0] {
      OP_INVALID = 6'd0,
      OP_LUI     = 6'd1,
      OP_AUIPC   = 6'd2,
      OP_JAL     = 6'd3,
      OP_JALR    = 6'd4,
      OP_BEQ     = 6'd5,
      OP_BNE     = 6'd6,
      OP_BLT     = 6'd7,
      OP_BGE     = 6'd8,
      OP_BLTU    = 6'd9,
      OP_BGEU    = 6'd10,
      OP_LB      = 6'd11,
      OP_LH      = 6'd12,
      OP_LW      = 6'd13,
      OP_LBU     = 6'd14,
      OP_LHU     = 6'd15,
      OP_SB      = 6'd16,
      OP_SH      = 6'd17,
      OP_SW      = 6'd18,
      OP_ADDI    = 6'd19,
      OP_SLTI    = 6'd20,
      OP_SLTIU   = 6'd21,
      OP_XORI    = 6'd22,
      OP_ORI     = 6'd23,
      OP_ANDI    = 6'd24,
      OP_SLLI    = 6'd25,
      OP_SRLI    = 6'd26,
      OP_SRAI    = 6'd27,
      OP_ADD     = 6'd28,
      OP_SUB     = 6'd29,
      OP_SLL     = 6'd30,
      OP_SLT     = 6'd31,
      OP_SLTU    = 6'd32,
      OP_XOR     = 6'd33,
      OP_SRL     = 6'd34,
      OP_SRA     = 6'd35,
      OP_OR      = 6'd36,
      OP_AND     = 6'd37,
      OP_FENCE   = 6'd38,
      OP_ECALL   = 6'd39,
      OP_EBREAK  = 6'd40,
      OP_LWU     = 6'd41,
      OP_LD      = 6'd42,
      OP_SD      = 6'd43,
      OP_ADDIW   = 6'd44,
      OP_SLLIW   = 6'd45,
      OP_SRLIW   = 6'd46,
      OP_SRAIW   = 6'd47,
      OP_ADDW    = 6'd48,
      OP_SUBW    = 6'd49,
      OP_SLLW    = 6'd50,
      OP_SRLW    = 6'd51,
      OP_SRAW    = 6'd52
   } op_kind_type;

   typedef struct packed {
      op_kind_type                 op_kind;
      logic [4:0]                  dest_reg;
      logic [4:0]                  src1_reg;
      logic [4:0]                  src2_reg;
      logic signed [ImmWidth-1:0]  immediate;
      logic [5:0]                  shift_amount;
   } decode_type;

endpackage

/* src/rvid_decode.sv */
// ----------------------------------------------------------------------------
// rvid_decode
// Combinational field extraction for one RV64I instruction word.
// ----------------------------------------------------------------------------
module rvid_decode
   import rvid_pkg::*;
(
   input  logic [InstrWidth-1:0] instr_word,
   output decode_type            result
);

   logic [6:0]          opc;
   logic [2:0]          f3;
   logic [6:0]          f7;
   logic [5:0]          f6;
   logic [4:0]          rd;
   logic [4:0]          rs1;
   logic [4:0]          rs2;
   logic [ImmWidth-1:0] imm_i;
   logic [ImmWidth-1:0] imm_u;
   logic [ImmWidth-1:0] imm_j;
   logic [ImmWidth-1:0] imm_b;
   logic [ImmWidth-1:0] imm_s;
   decode_type          raw;

   assign opc = instr_word[6:0];
   assign rd  = instr_word[11:7];
   assign f3  = instr_word[14:12];
   assign rs1 = instr_word[19:15];
   assign rs2 = instr_word[24:20];
   assign f7  = instr_word[31:25];
   assign f6  = instr_word[31:26];

   assign imm_i = {{52{instr_word[31]}}, instr_word[31:20]};
   assign imm_u = {{32{instr_word[31]}}, instr_word[31:12], 12'b0};
   assign imm_j = {{44{instr_word[31]}}, instr_word[19:12], instr_word[20],
                   instr_word[30:21], 1'b0};
   assign imm_b = {{52{instr_word[31]}}, instr_word[7], instr_word[30:25],
                   instr_word[11:8], 1'b0};
   assign imm_s = {{52{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};

   always_comb begin
      raw = '0;
      raw.op_kind = OP_INVALID;
      unique case (opc)
         OPC_LUI, OPC_AUIPC: begin
            raw.op_kind   = (opc == OPC_LUI) ? OP_LUI : OP_AUIPC;
            raw.dest_reg  = rd;
            raw.immediate = imm_u;
         end
         OPC_JAL: begin
            raw.op_kind   = OP_JAL;
            raw.dest_reg  = rd;
            raw.immediate = imm_j;
         end
         OPC_JALR: begin
            if (f3 == 3'd0) begin
               raw.op_kind   = OP_JALR;
               raw.dest_reg  = rd;
               raw.src1_reg  = rs1;
               raw.immediate = imm_i;
            end
         end
         OPC_BRANCH: begin
            unique case (f3)
               3'd0:    raw.op_kind = OP_BEQ;
               3'd1:    raw.op_kind = OP_BNE;
               3'd4:    raw.op_kind = OP_BLT;
               3'd5:    raw.op_kind = OP_BGE;
               3'd6:    raw.op_kind = OP_BLTU;
               3'd7:    raw.op_kind = OP_BGEU;
               default: raw.op_kind = OP_INVALID;
            endcase
            raw.src1_reg  = rs1;
            raw.src2_reg  = rs2;
            raw.immediate = imm_b;
         end
         OPC_LOAD: begin
            unique case (f3)
               3'd0:    raw.op_kind = OP_LB;
               3'd1:    raw.op_kind = OP_LH;
               3'd2:    raw.op_kind = OP_LW;
               3'd3:    raw.op_kind = OP_LD;
               3'd4:    raw.op_kind = OP_LBU;
               3'd5:    raw.op_kind = OP_LHU;
               3'd6:    raw.op_kind = OP_LWU;
               default: raw.op_kind = OP_INVALID;
            endcase
            raw.dest_reg  = rd;
            raw.src1_reg  = rs1;
            raw.immediate = imm_i;
         end
         OPC_STORE: begin
            unique case (f3)
               3'd0:    raw.op_kind = OP_SB;
               3'd1:    raw.op_kind = OP_SH;
               3'd2:    raw.op_kind = OP_SW;
               3'd3:    raw.op_kind = OP_SD;
               default: raw.op_kind = OP_INVALID;
            endcase
            raw.src1_reg  = rs1;
            raw.src2_reg  = rs2;
            raw.immediate = imm_s;
         end
         OPC_OPIMM: begin
            raw.dest_reg = rd;
            raw.src1_reg = rs1;
            unique case (f3)
               3'd1: begin
                  if (f6 == F6_BASE) raw.op_kind = OP_SLLI;
                  raw.shift_amount = instr_word[25:20];
               end
               3'd5: begin
                  if (f6 == F6_BASE)     raw.op_kind = OP_SRLI;
                  else if (f6 == F6_ALT) raw.op_kind = OP_SRAI;
                  raw.shift_amount = instr_word[25:20];
               end
               3'd0: begin raw.op_kind = OP_ADDI;  raw.immediate = imm_i; end
               3'd2: begin raw.op_kind = OP_SLTI;  raw.immediate = imm_i; end
               3'd3: begin raw.op_kind = OP_SLTIU; raw.immediate = imm_i; end
               3'd4: begin raw.op_kind = OP_XORI;  raw.immediate = imm_i; end
               3'd6: begin raw.op_kind = OP_ORI;   raw.immediate = imm_i; end
               3'd7: begin raw.op_kind = OP_ANDI;  raw.immediate = imm_i; end
               default: raw.op_kind = OP_INVALID;
            endcase
         end
         OPC_OP: begin
            if (f7 == F7_BASE) begin
               unique case (f3)
                  3'd0:    raw.op_kind = OP_ADD;
                  3'd1:    raw.op_kind = OP_SLL;
                  3'd2:    raw.op_kind = OP_SLT;
                  3'd3:    raw.op_kind = OP_SLTU;
                  3'd4:    raw.op_kind = OP_XOR;
                  3'd5:    raw.op_kind = OP_SRL;
                  3'd6:    raw.op_kind = OP_OR;
                  3'd7:    raw.op_kind = OP_AND;
                  default: raw.op_kind = OP_INVALID;
               endcase
            end else if (f7 == F7_ALT && f3 == 3'd0) begin
               raw.op_kind = OP_SUB;
            end else if (f7 == F7_ALT && f3 == 3'd5) begin
               raw.op_kind = OP_SRA;
            end
            raw.dest_reg = rd;
            raw.src1_reg = rs1;
            raw.src2_reg = rs2;
         end
         OPC_FENCE: begin
            if (f3 == 3'd0) begin
               raw.op_kind   = OP_FENCE;
               raw.dest_reg  = rd;
               raw.src1_reg  = rs1;
               raw.immediate = imm_i;
            end
         end
         OPC_SYSTEM: begin
            // only the bare ECALL / EBREAK words
            if (f3 == 3'd0 && rd == 5'd0 && rs1 == 5'd0) begin
               if (instr_word[31:20] == F12_ECALL)       raw.op_kind = OP_ECALL;
               else if (instr_word[31:20] == F12_EBREAK) raw.op_kind = OP_EBREAK;
            end
         end
         OPC_OPIMMW: begin
            raw.dest_reg = rd;
            raw.src1_reg = rs1;
            if (f3 == 3'd0) begin
               raw.op_kind   = OP_ADDIW;
               raw.immediate = imm_i;
            end else begin
               // bit 25 set is reserved, caught by the full funct7 compare
               raw.shift_amount = {1'b0, rs2};
               if (f3 == 3'd1 && f7 == F7_BASE)      raw.op_kind = OP_SLLIW;
               else if (f3 == 3'd5 && f7 == F7_BASE) raw.op_kind = OP_SRLIW;
               else if (f3 == 3'd5 && f7 == F7_ALT)  raw.op_kind = OP_SRAIW;
            end
         end
         OPC_OPW: begin
            if (f3 == 3'd0 && f7 == F7_BASE)      raw.op_kind = OP_ADDW;
            else if (f3 == 3'd0 && f7 == F7_ALT)  raw.op_kind = OP_SUBW;
            else if (f3 == 3'd1 && f7 == F7_BASE) raw.op_kind = OP_SLLW;
            else if (f3 == 3'd5 && f7 == F7_BASE) raw.op_kind = OP_SRLW;
            else if (f3 == 3'd5 && f7 == F7_ALT)  raw.op_kind = OP_SRAW;
            raw.dest_reg = rd;
            raw.src1_reg = rs1;
            raw.src2_reg = rs2;
         end
         default: raw.op_kind = OP_INVALID;
      endcase
   end

   // an invalid word shows nothing but a zero op code
   always_comb begin
      if (raw.op_kind == OP_INVALID) begin
         result = '0;
      end else begin
         result = raw;
      end
   end

endmodule

/* src/rv64i_instruction_decoder.sv */
// ----------------------------------------------------------------------------
// rv64i_instruction_decoder
// RV64I instruction decoder: one word in, one decoded item out.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_instr_word and raise start; the word is taken at any
//   rising edge where start is high and busy is low.
//   Output: rsp_valid pulses for one cycle with the decoded fields on the
//   rsp_ ports. The receiver cannot stall; results are never held back.
//   The word passes through the input register, the decode logic and the
//   result register. Throughput: one item per cycle, back to back.
//   Unused fields come out zero; an invalid word gives op_kind zero with all
//   other fields zero.
//   Reset (synchronous, active high) drops any items in flight; busy is reset
//   delayed by a register: high in the cycle after each cycle of reset, low otherwise.
// ----------------------------------------------------------------------------
module rv64i_instruction_decoder
   import rvid_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [InstrWidth-1:0]       req_instr_word,
   output logic                        rsp_valid,
   output logic [5:0]                  rsp_op_kind,
   output logic [4:0]                  rsp_dest_reg,
   output logic [4:0]                  rsp_src1_reg,
   output logic [4:0]                  rsp_src2_reg,
   output logic signed [ImmWidth-1:0]  rsp_immediate,
   output logic [5:0]                  rsp_shift_amount
);

   logic                  busy_ff;
   logic                  word_valid_ff;
   logic                  word_valid_in;
   logic [InstrWidth-1:0] word_ff;
   logic                  rsp_valid_ff;
   decode_type            decoded;
   decode_type            rsp_ff;

   assign busy          = busy_ff;
   assign word_valid_in = start & ~busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
      if (reset) begin
         word_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= word_valid_ff;
      end
      if (word_valid_in) begin
         word_ff <= req_instr_word;
      end
      if (word_valid_ff) begin
         rsp_ff <= decoded;
      end
   end

   rvid_decode u_decode (
      .instr_word (word_ff),
      .result     (decoded)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_op_kind      = rsp_ff.op_kind;
   assign rsp_dest_reg     = rsp_ff.dest_reg;
   assign rsp_src1_reg     = rsp_ff.src1_reg;
   assign rsp_src2_reg     = rsp_ff.src2_reg;
   assign rsp_immediate    = rsp_ff.immediate;
   assign rsp_shift_amount = rsp_ff.shift_amount;

endmodule

/* src/rvid_checker.sv */
// ----------------------------------------------------------------------------
// rvid_checker
// Port-level checks for the RV64I instruction decoder, bound to the top.
// ----------------------------------------------------------------------------
module rvid_checker
   import rvid_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       start,
   input logic                       busy,
   input logic                       rsp_valid,
   input logic [5:0]                 rsp_op_kind,
   input logic [4:0]                 rsp_dest_reg,
   input logic [4:0]                 rsp_src1_reg,
   input logic [4:0]                 rsp_src2_reg,
   input logic signed [ImmWidth-1:0] rsp_immediate,
   input logic [5:0]                 rsp_shift_amount
);

   // every accepted item produces a result on rsp_valid
   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("accepted item did not produce a result");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result without an accepted item");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_op_kind == OP_INVALID) |->
         (rsp_dest_reg == 5'd0 && rsp_src1_reg == 5'd0 && rsp_src2_reg == 5'd0
          && rsp_immediate == '0 && rsp_shift_amount == 6'd0))
      else $error("invalid item carries nonzero fields");

   a_shamt_kind : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_shift_amount != 6'd0) |->
         (rsp_op_kind == OP_SLLI || rsp_op_kind == OP_SRLI || rsp_op_kind == OP_SRAI
          || rsp_op_kind == OP_SLLIW || rsp_op_kind == OP_SRLIW
          || rsp_op_kind == OP_SRAIW))
      else $error("shift amount on a non-shift item");

   a_w_shamt : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_op_kind == OP_SLLIW || rsp_op_kind == OP_SRLIW
                     || rsp_op_kind == OP_SRAIW)) |-> !rsp_shift_amount[5])
      else $error("word shift with shift amount above 31");

endmodule

bind rv64i_instruction_decoder rvid_checker u_rvid_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_op_kind      (rsp_op_kind),
   .rsp_dest_reg     (rsp_dest_reg),
   .rsp_src1_reg     (rsp_src1_reg),
   .rsp_src2_reg     (rsp_src2_reg),
   .rsp_immediate    (rsp_immediate),
   .rsp_shift_amount (rsp_shift_amount)
);
